@@ src/latching_relay_drive_controller_defines.svh @@
// Assertion macros for the latching relay drive controller.
// Depends on nothing; included by the RTL modules that carry checks.
`ifndef LATCHING_RELAY_DRIVE_CONTROLLER_DEFINES_SVH
`define LATCHING_RELAY_DRIVE_CONTROLLER_DEFINES_SVH

// Check a property on the rising clock edge, masked while reset is held.
`define LRDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on the rising clock edge, also during reset.
`define LRDC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/lrdc_pkg.sv @@
// Shared types and constants for the latching relay drive controller.
// No dependencies; imported by the top level.
package lrdc_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int TIMEOUT_W      = 16;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_ADDR_W     = 5;
  localparam int OPCODE_W       = 3;
  localparam int WVAL_W         = 8;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd1000;

  // Bit positions inside the drive line vector.
  localparam int LN_A    = 0;
  localparam int LN_B    = 1;
  localparam int LN_DATA = 2;
  localparam int LN_EN   = 3;

  typedef enum logic [1:0] {
    ST_IDLE      = 2'd0,
    ST_DRV_RESET = 2'd1,
    ST_DRV_SET   = 2'd2,
    ST_FAULT     = 2'd3
  } motion_t;

  typedef enum logic [1:0] {
    LOC_RESET   = 2'd0,
    LOC_SET     = 2'd1,
    LOC_UNKNOWN = 2'd2
  } location_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK      = 3'd0,
    OP_DRV_RESET = 3'd1,
    OP_DRV_SET   = 3'd2,
    OP_STOP      = 3'd3,
    OP_RST_MODE  = 3'd4,
    OP_WRITE     = 3'd5,
    OP_READ      = 3'd6
  } opcode_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_INVALID  = 2'd1,
    STS_TIMEOUT  = 2'd2,
    STS_HW_FAULT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_TIMEOUT   = 3'd0,
    REG_MODE      = 3'd1,
    REG_RST_PRES  = 3'd2,
    REG_RST_AHIGH = 3'd3,
    REG_SET_PRES  = 3'd4,
    REG_SET_AHIGH = 3'd5
  } reg_idx_t;

  // Feedback activity: an absent line reads as 0, then polarity applies.
  function automatic logic line_active(input logic level, input logic present,
                                       input logic high);
    return (present & level) ~^ high;
  endfunction

endpackage

@@ src/latching_relay_drive_controller.sv @@
// Latching relay drive controller: command decode, endstop/timeout handling,
// result register and APB-style configuration registers.
// Depends on lrdc_pkg and latching_relay_drive_controller_defines.svh.
//
//  channel | handshake            | beat contents
//  --------+----------------------+-----------------------------------------------
//  in      | in_valid / in_stall  | opcode, write_value, two feedback samples
//  out     | out_valid / out_stall| status, position, drive lines, state, events
//  cfg     | psel/penable/pready  | six registers at byte address 4*index
//
// One item per cycle unless in_stall is high: each beat is handled by a single
// combinational pass from ports and state registers into the result register.
// The result register is the only buffer, so in_stall rises only while a
// result is held and out_stall is high. Reset (rst_n low, synchronous) idles
// the relay, drops all drive lines and marks the position unknown.
`include "latching_relay_drive_controller_defines.svh"

module latching_relay_drive_controller #(
  parameter int TIMER_BITS = lrdc_pkg::TIMER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [lrdc_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic [lrdc_pkg::WVAL_W-1:0]       in_write_value,
  input  logic                              in_reset_feedback_level,
  input  logic                              in_set_feedback_level,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [1:0]                        out_position,
  output logic                              out_drive_a,
  output logic                              out_drive_b,
  output logic                              out_data_line,
  output logic                              out_enable_line,
  output logic [1:0]                        out_drive_state,
  output logic                              out_reset_active,
  output logic                              out_set_active,
  output logic                              out_endstop_event,
  output logic                              out_timeout_event,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [lrdc_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [lrdc_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [lrdc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import lrdc_pkg::*;

  localparam int EL_W = TIMER_BITS + 1;

  // ---------------------------------------------------------------- config
  logic [TIMEOUT_W-1:0] timeout_r;
  logic                 mode_r;
  logic                 rst_pres_r, rst_ahigh_r, set_pres_r, set_ahigh_r;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= TIMEOUT_RST;
      mode_r      <= 1'b0;
      rst_pres_r  <= 1'b1;
      rst_ahigh_r <= 1'b1;
      set_pres_r  <= 1'b1;
      set_ahigh_r <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TIMEOUT:   timeout_r   <= pwdata[TIMEOUT_W-1:0];
        REG_MODE:      mode_r      <= pwdata[0];
        REG_RST_PRES:  rst_pres_r  <= pwdata[0];
        REG_RST_AHIGH: rst_ahigh_r <= pwdata[0];
        REG_SET_PRES:  set_pres_r  <= pwdata[0];
        REG_SET_AHIGH: set_ahigh_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TIMEOUT:   prdata = {{(CFG_DATA_W-TIMEOUT_W){1'b0}}, timeout_r};
      REG_MODE:      prdata = {{(CFG_DATA_W-1){1'b0}}, mode_r};
      REG_RST_PRES:  prdata = {{(CFG_DATA_W-1){1'b0}}, rst_pres_r};
      REG_RST_AHIGH: prdata = {{(CFG_DATA_W-1){1'b0}}, rst_ahigh_r};
      REG_SET_PRES:  prdata = {{(CFG_DATA_W-1){1'b0}}, set_pres_r};
      REG_SET_AHIGH: prdata = {{(CFG_DATA_W-1){1'b0}}, set_ahigh_r};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- state
  motion_t          motion_r, motion_nxt;
  location_t        loc_r, loc_nxt;
  logic [EL_W-1:0]  elapsed_r, elapsed_nxt;
  logic [3:0]       lines_r, lines_nxt;
  logic [1:0]       prev_fb_r;

  logic             accept;
  logic             r_now, s_now, r_prev, s_prev;
  logic             ev_end, ev_to;
  logic             ract_mid, sact_mid;
  motion_t          motion_mid;
  location_t        loc_mid;
  logic [TIMER_BITS-1:0] tmo_eff;
  logic             drv_tgt_set, drv_blocked;

  assign accept  = in_valid & ~in_stall;
  assign in_stall = out_valid & out_stall;
  assign tmo_eff = TIMER_BITS'(timeout_r);

  assign r_now  = line_active(in_reset_feedback_level, rst_pres_r, rst_ahigh_r);
  assign s_now  = line_active(in_set_feedback_level, set_pres_r, set_ahigh_r);
  assign r_prev = line_active(prev_fb_r[0], rst_pres_r, rst_ahigh_r);
  assign s_prev = line_active(prev_fb_r[1], set_pres_r, set_ahigh_r);

  // Next state: endstop edge first, then the command.
  always_comb begin
    motion_nxt  = motion_r;
    loc_nxt     = loc_r;
    elapsed_nxt = elapsed_r;
    lines_nxt   = lines_r;
    ev_end      = 1'b0;
    ev_to       = 1'b0;
    drv_tgt_set = (opcode_t'(in_opcode) == OP_DRV_SET) ||
                  (opcode_t'(in_opcode) == OP_WRITE && in_write_value == 8'd1);

    if (motion_r == ST_DRV_RESET && rst_pres_r && r_now && !r_prev) begin
      lines_nxt[mode_r ? LN_EN : LN_A] = 1'b0;
      loc_nxt     = LOC_RESET;
      motion_nxt  = ST_IDLE;
      elapsed_nxt = '0;
      ev_end      = 1'b1;
    end else if (motion_r == ST_DRV_SET && set_pres_r && s_now && !s_prev) begin
      lines_nxt[mode_r ? LN_EN : LN_B] = 1'b0;
      loc_nxt     = LOC_SET;
      motion_nxt  = ST_IDLE;
      elapsed_nxt = '0;
      ev_end      = 1'b1;
    end

    motion_mid  = motion_nxt;
    loc_mid     = loc_nxt;
    ract_mid    = r_now || (loc_nxt == LOC_RESET);
    sact_mid    = s_now || (loc_nxt == LOC_SET);
    drv_blocked = drv_tgt_set ? sact_mid : ract_mid;

    case (opcode_t'(in_opcode))
      OP_TICK: begin
        if (!ev_end && (motion_nxt == ST_DRV_RESET || motion_nxt == ST_DRV_SET)) begin
          if (!(&elapsed_nxt)) elapsed_nxt = elapsed_nxt + 1'b1;
          if (elapsed_nxt > {1'b0, tmo_eff}) begin
            elapsed_nxt = '0;
            if (mode_r) lines_nxt[LN_EN] = 1'b0;
            else        lines_nxt[LN_B:LN_A] = 2'b00;
            motion_nxt = ST_FAULT;
            loc_nxt    = LOC_UNKNOWN;
            ev_to      = 1'b1;
          end
        end
      end
      OP_DRV_RESET, OP_DRV_SET, OP_WRITE, OP_STOP: begin
        if (opcode_t'(in_opcode) != OP_WRITE || in_write_value <= 8'd1) begin
          // stop
          if (motion_nxt != ST_FAULT) motion_nxt = ST_IDLE;
          elapsed_nxt = '0;
          if (mode_r) lines_nxt[LN_EN] = 1'b0;
          else        lines_nxt[LN_B:LN_A] = 2'b00;
          // then drive, unless the target already reads active
          if (opcode_t'(in_opcode) != OP_STOP && !drv_blocked) begin
            motion_nxt = drv_tgt_set ? ST_DRV_SET : ST_DRV_RESET;
            loc_nxt    = LOC_UNKNOWN;
            if (mode_r) begin
              lines_nxt[LN_EN]   = 1'b1;
              lines_nxt[LN_DATA] = drv_tgt_set;
            end else begin
              lines_nxt[LN_B:LN_A] = drv_tgt_set ? 2'b10 : 2'b01;
            end
          end
        end
      end
      OP_RST_MODE: begin
        // a reset drive that is stopped at once
        if (!ract_mid) begin
          motion_nxt = ST_IDLE;
          loc_nxt    = LOC_UNKNOWN;
          if (mode_r) lines_nxt[LN_DATA] = 1'b0;
        end else if (motion_nxt != ST_FAULT) begin
          motion_nxt = ST_IDLE;
        end
        elapsed_nxt = '0;
        if (mode_r) lines_nxt[LN_EN] = 1'b0;
        else        lines_nxt[LN_B:LN_A] = 2'b00;
      end
      default: ;
    endcase
  end

  // Result fields.
  status_t   sts_nxt;
  location_t pos_nxt;

  always_comb begin
    sts_nxt = STS_OK;
    pos_nxt = LOC_RESET;
    case (opcode_t'(in_opcode))
      OP_WRITE: begin
        if (in_write_value > 8'd1) sts_nxt = STS_INVALID;
      end
      OP_READ: begin
        if (motion_mid == ST_FAULT) begin
          sts_nxt = STS_TIMEOUT;
          pos_nxt = LOC_UNKNOWN;
        end else if (ract_mid && sact_mid) begin
          sts_nxt = STS_HW_FAULT;
          pos_nxt = LOC_UNKNOWN;
        end else if (ract_mid) begin
          pos_nxt = LOC_RESET;
        end else if (sact_mid) begin
          pos_nxt = LOC_SET;
        end else begin
          pos_nxt = loc_mid;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      motion_r  <= ST_IDLE;
      loc_r     <= LOC_UNKNOWN;
      elapsed_r <= '0;
      lines_r   <= '0;
      prev_fb_r <= '0;
    end else if (accept) begin
      motion_r  <= motion_nxt;
      loc_r     <= loc_nxt;
      elapsed_r <= elapsed_nxt;
      lines_r   <= lines_nxt;
      prev_fb_r <= {in_set_feedback_level, in_reset_feedback_level};
    end
  end

  // ---------------------------------------------------------------- result
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status        <= sts_nxt;
      out_position      <= pos_nxt;
      out_drive_a       <= lines_nxt[LN_A];
      out_drive_b       <= lines_nxt[LN_B];
      out_data_line     <= lines_nxt[LN_DATA];
      out_enable_line   <= lines_nxt[LN_EN];
      out_drive_state   <= motion_nxt;
      out_reset_active  <= r_now || (loc_nxt == LOC_RESET);
      out_set_active    <= s_now || (loc_nxt == LOC_SET);
      out_endstop_event <= ev_end;
      out_timeout_event <= ev_to;
    end
  end

  assign out_valid = out_valid_r;

  // ---------------------------------------------------------------- checks
  `LRDC_ASSERT_ALWAYS(a_stall_needs_result, in_stall |-> out_valid, "stall without result")
  `LRDC_ASSERT(a_accept_gives_result, accept |=> out_valid, "beat gave no result")
  `LRDC_ASSERT(a_ev_excl, out_valid |-> !(out_endstop_event && out_timeout_event), "two events")
  `LRDC_ASSERT(a_to_fault, out_valid && out_timeout_event |-> out_drive_state == ST_FAULT, "no fault")
  `LRDC_ASSERT(a_end_ok, out_valid && out_endstop_event |-> out_drive_state != ST_FAULT, "faulted")

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for latching_relay_drive_controller.
// Drives command beats with random idling, predicts every result beat and compares it.
// Depends on lrdc_pkg and the controller RTL; reads no files.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lrdc_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  typedef struct {
    logic [1:0] status;
    logic [1:0] position;
    logic       drive_a;
    logic       drive_b;
    logic       data_line;
    logic       enable_line;
    logic [1:0] drive_state;
    logic       reset_active;
    logic       set_active;
    logic       endstop;
    logic       timed_out;
  } relay_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [OPCODE_W-1:0] in_opcode = '0;
  logic [WVAL_W-1:0] in_write_value = '0;
  logic in_reset_feedback_level = 1'b0;
  logic in_set_feedback_level = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status, out_position, out_drive_state;
  logic out_drive_a, out_drive_b, out_data_line, out_enable_line;
  logic out_reset_active, out_set_active, out_endstop_event, out_timeout_event;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  // Register shadow.
  logic [15:0] reg_timeout = TIMEOUT_RST;
  logic reg_mode = 1'b0;
  logic reg_rst_pres = 1'b1;
  logic reg_rst_high = 1'b1;
  logic reg_set_pres = 1'b1;
  logic reg_set_high = 1'b1;

  // Relay state shadow.
  motion_t mstate = ST_IDLE;
  location_t loc = LOC_UNKNOWN;
  logic [16:0] elapsed = '0;
  logic [3:0] lines = '0;
  logic [1:0] prev_fb = '0;

  relay_beat_t expected_beats[$];
  int err_count = 0;
  int sent_count = 0;
  int out_count = 0;
  int quiet = 0;
  bit calm = 1'b0;

  latching_relay_drive_controller u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_write_value(in_write_value),
    .in_reset_feedback_level(in_reset_feedback_level),
    .in_set_feedback_level(in_set_feedback_level),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_position(out_position), .out_drive_a(out_drive_a), .out_drive_b(out_drive_b),
    .out_data_line(out_data_line), .out_enable_line(out_enable_line),
    .out_drive_state(out_drive_state), .out_reset_active(out_reset_active),
    .out_set_active(out_set_active), .out_endstop_event(out_endstop_event),
    .out_timeout_event(out_timeout_event),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // ---------------- predictor ----------------

  // Absent lines read as 0 before the polarity is applied.
  function automatic logic fb_active(logic level, logic present, logic high);
    logic l;
    l = present & level;
    return high ? l : ~l;
  endfunction

  function automatic void halt_drive();
    if (mstate != ST_FAULT) mstate = ST_IDLE;
    elapsed = '0;
    if (reg_mode) begin
      lines[LN_EN] = 1'b0;
    end else begin
      lines[LN_A] = 1'b0;
      lines[LN_B] = 1'b0;
    end
  endfunction

  function automatic void start_drive(logic to_set, logic r_now, logic s_now);
    logic r_act, s_act;
    r_act = r_now || loc == LOC_RESET;
    s_act = s_now || loc == LOC_SET;
    if (to_set ? s_act : r_act) return;
    mstate = to_set ? ST_DRV_SET : ST_DRV_RESET;
    loc = LOC_UNKNOWN;
    if (reg_mode) begin
      lines[LN_EN] = 1'b1;
      lines[LN_DATA] = to_set;
    end else begin
      lines[LN_A] = ~to_set;
      lines[LN_B] = to_set;
    end
    elapsed = '0;
  endfunction

  function automatic relay_beat_t relay_step(logic [2:0] op, logic [7:0] wv,
                                             logic rl, logic sl);
    relay_beat_t r;
    logic r_now, s_now, r_act, s_act, ev_end, ev_to;
    logic [1:0] status, position;
    r_now = fb_active(rl, reg_rst_pres, reg_rst_high);
    s_now = fb_active(sl, reg_set_pres, reg_set_high);
    ev_end = 1'b0;
    ev_to = 1'b0;
    status = STS_OK;
    position = LOC_RESET;
    // Endstop edge comes before the command.
    if (mstate == ST_DRV_RESET && reg_rst_pres && r_now &&
        !fb_active(prev_fb[0], reg_rst_pres, reg_rst_high)) begin
      if (reg_mode) lines[LN_EN] = 1'b0;
      else lines[LN_A] = 1'b0;
      loc = LOC_RESET;
      mstate = ST_IDLE;
      elapsed = '0;
      ev_end = 1'b1;
    end else if (mstate == ST_DRV_SET && reg_set_pres && s_now &&
                 !fb_active(prev_fb[1], reg_set_pres, reg_set_high)) begin
      if (reg_mode) lines[LN_EN] = 1'b0;
      else lines[LN_B] = 1'b0;
      loc = LOC_SET;
      mstate = ST_IDLE;
      elapsed = '0;
      ev_end = 1'b1;
    end
    prev_fb = {sl, rl};

    case (op)
      OP_TICK: begin
        if (!ev_end && (mstate == ST_DRV_RESET || mstate == ST_DRV_SET)) begin
          if (elapsed != '1) elapsed = elapsed + 1'b1;
          if (elapsed > {1'b0, reg_timeout}) begin
            halt_drive();
            mstate = ST_FAULT;
            loc = LOC_UNKNOWN;
            ev_to = 1'b1;
          end
        end
      end
      OP_DRV_RESET, OP_DRV_SET: begin
        halt_drive();
        start_drive(op == OP_DRV_SET, r_now, s_now);
      end
      OP_STOP: halt_drive();
      OP_RST_MODE: begin
        start_drive(1'b0, r_now, s_now);
        halt_drive();
      end
      OP_WRITE: begin
        if (wv > 8'd1) begin
          status = STS_INVALID;
        end else begin
          halt_drive();
          start_drive(wv == 8'd1, r_now, s_now);
        end
      end
      OP_READ: begin
        r_act = r_now || loc == LOC_RESET;
        s_act = s_now || loc == LOC_SET;
        if (mstate == ST_FAULT) begin
          status = STS_TIMEOUT;
          position = LOC_UNKNOWN;
        end else if (r_act && s_act) begin
          status = STS_HW_FAULT;
          position = LOC_UNKNOWN;
        end else if (r_act) begin
          position = LOC_RESET;
        end else if (s_act) begin
          position = LOC_SET;
        end else begin
          position = loc;
        end
      end
      default: ;
    endcase

    r.status = status;
    r.position = position;
    r.drive_a = lines[LN_A];
    r.drive_b = lines[LN_B];
    r.data_line = lines[LN_DATA];
    r.enable_line = lines[LN_EN];
    r.drive_state = mstate;
    r.reset_active = r_now || loc == LOC_RESET;
    r.set_active = s_now || loc == LOC_SET;
    r.endstop = ev_end;
    r.timed_out = ev_to;
    return r;
  endfunction

  // ---------------- checking ----------------

  task automatic log_error(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic cmp(input string name, input logic [1:0] got, input logic [1:0] want);
    if (got !== want)
      log_error($sformatf("beat %0d %s: got %0d, want %0d", out_count, name, got, want));
  endtask

  always @(posedge clk) begin : monitor
    relay_beat_t want;
    logic took_in, took_out;
    took_in = rst_n && in_valid && !in_stall;
    took_out = rst_n && out_valid && !out_stall;
    if (took_in)
      expected_beats.push_back(relay_step(in_opcode, in_write_value,
                                          in_reset_feedback_level, in_set_feedback_level));
    if (took_out) begin
      out_count++;
      if (expected_beats.size() == 0) begin
        log_error($sformatf("beat %0d arrived with nothing pending", out_count));
      end else begin
        want = expected_beats.pop_front();
        cmp("status", out_status, want.status);
        cmp("position", out_position, want.position);
        cmp("drive_a", 2'(out_drive_a), 2'(want.drive_a));
        cmp("drive_b", 2'(out_drive_b), 2'(want.drive_b));
        cmp("data_line", 2'(out_data_line), 2'(want.data_line));
        cmp("enable_line", 2'(out_enable_line), 2'(want.enable_line));
        cmp("drive_state", out_drive_state, want.drive_state);
        cmp("reset_active", 2'(out_reset_active), 2'(want.reset_active));
        cmp("set_active", 2'(out_set_active), 2'(want.set_active));
        cmp("endstop_event", 2'(out_endstop_event), 2'(want.endstop));
        cmp("timeout_event", 2'(out_timeout_event), 2'(want.timed_out));
      end
    end
    if (!rst_n || took_in || took_out) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Random back-pressure on the result side.
  always @(posedge clk) out_stall <= !calm && $urandom_range(99) < 23;

  // ---------------- stimulus helpers ----------------

  task automatic send_item(input logic [2:0] op, input logic [7:0] wv,
                           input logic rl, input logic sl);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_write_value <= wv;
    in_reset_feedback_level <= rl;
    in_set_feedback_level <= sl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // Drain all pending beats, then leave room for the result register.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_TIMEOUT:   reg_timeout = val[15:0];
      REG_MODE:      reg_mode = val[0];
      REG_RST_PRES:  reg_rst_pres = val[0];
      REG_RST_AHIGH: reg_rst_high = val[0];
      REG_SET_PRES:  reg_set_pres = val[0];
      REG_SET_AHIGH: reg_set_high = val[0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(input logic [15:0] t, input logic m, input logic rp,
                             input logic rh, input logic sp, input logic sh);
    settle();
    write_reg(REG_TIMEOUT, {16'd0, t});
    write_reg(REG_MODE, {31'd0, m});
    write_reg(REG_RST_PRES, {31'd0, rp});
    write_reg(REG_RST_AHIGH, {31'd0, rh});
    write_reg(REG_SET_PRES, {31'd0, sp});
    write_reg(REG_SET_AHIGH, {31'd0, sh});
  endtask

  // Feedback level for the line being driven toward; the other line is random.
  task automatic send_toward(input logic to_set, input logic active, input logic [2:0] op,
                             input logic [7:0] wv);
    logic lvl;
    lvl = active ? (to_set ? reg_set_high : reg_rst_high)
                 : ~(to_set ? reg_set_high : reg_rst_high);
    if (to_set) send_item(op, wv, 1'($urandom_range(1)), lvl);
    else send_item(op, wv, lvl, 1'($urandom_range(1)));
  endtask

  // Launch, tick for a while with the target quiet, then hit the endstop.
  task automatic run_motion();
    logic to_set;
    logic [2:0] op;
    int n, cap;
    to_set = 1'($urandom_range(1));
    if ($urandom_range(1)) send_toward(to_set, 1'b0, to_set ? OP_DRV_SET : OP_DRV_RESET,
                                       8'($urandom_range(255)));
    else send_toward(to_set, 1'b0, OP_WRITE, {7'd0, to_set});
    cap = (reg_timeout < 30) ? int'(reg_timeout) + 2 : 30;
    n = $urandom_range(cap);
    repeat (n) begin
      op = ($urandom_range(9) == 0) ? OP_READ : OP_TICK;
      send_toward(to_set, 1'b0, op, 8'($urandom_range(255)));
    end
    op = ($urandom_range(1) == 0) ? OP_TICK : 3'($urandom_range(7));
    send_toward(to_set, 1'b1, op, 8'($urandom_range(1)));
    if ($urandom_range(1))
      send_item(OP_READ, 8'($urandom_range(255)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
  endtask

  task automatic random_phase(input int n_items);
    int stop_at;
    logic [7:0] wv;
    stop_at = sent_count + n_items;
    while (sent_count < stop_at) begin
      if ($urandom_range(9) < 7) begin
        run_motion();
      end else begin
        wv = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(1));
        send_item(3'($urandom_range(7)), wv, 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      end
    end
  endtask

  // ---------------- tests ----------------

  task automatic test_commands();
    send_item(OP_READ, 8'd0, 1'b0, 1'b0);
    send_item(3'd7, 8'd0, 1'b0, 1'b0);       // no-op opcode
    send_item(OP_DRV_SET, 8'd0, 1'b0, 1'b0);
    send_item(OP_TICK, 8'd0, 1'b0, 1'b0);
    send_item(OP_TICK, 8'd0, 1'b0, 1'b1);    // set endstop edge
    send_item(OP_READ, 8'd0, 1'b0, 1'b1);
    send_item(OP_DRV_SET, 8'd0, 1'b0, 1'b1); // already there
    send_item(OP_WRITE, 8'd0, 1'b0, 1'b1);
    send_item(OP_TICK, 8'd0, 1'b1, 1'b0);    // reset endstop edge
    send_item(OP_READ, 8'd0, 1'b1, 1'b1);    // both lines active
    send_item(OP_WRITE, 8'd255, 1'b1, 1'b0);
    send_item(OP_WRITE, 8'd2, 1'b0, 1'b0);
    send_item(OP_WRITE, 8'd1, 1'b0, 1'b0);
    send_item(OP_STOP, 8'd0, 1'b0, 1'b0);
    send_item(OP_RST_MODE, 8'd0, 1'b0, 1'b0);
    send_item(OP_RST_MODE, 8'd0, 1'b1, 1'b0);
    send_item(OP_DRV_RESET, 8'd0, 1'b0, 1'b0);
    send_item(OP_READ, 8'd0, 1'b0, 1'b0);    // read mid-motion
    send_item(OP_DRV_SET, 8'd128, 1'b0, 1'b0);
  endtask

  task automatic test_timeout();
    apply_setup(16'd0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
    send_item(OP_DRV_SET, 8'd0, 1'b0, 1'b0);
    send_item(OP_TICK, 8'd0, 1'b0, 1'b0);    // first tick already too late
    send_item(OP_READ, 8'd0, 1'b0, 1'b0);
    send_item(OP_TICK, 8'd0, 1'b0, 1'b0);
    send_item(OP_STOP, 8'd0, 1'b0, 1'b0);    // fault holds across stop
    send_item(OP_DRV_RESET, 8'd0, 1'b0, 1'b0);
  endtask

  task automatic test_feedback_polarity();
    // Absent active-low reset line counts as always active.
    apply_setup(16'd2, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
    send_item(OP_DRV_RESET, 8'd0, 1'b0, 1'b1);
    send_item(OP_READ, 8'd0, 1'b1, 1'b1);
    send_item(OP_DRV_SET, 8'd0, 1'b0, 1'b1);
    repeat (3) send_item(OP_TICK, 8'd0, 1'b0, 1'b1);
    send_item(OP_DRV_SET, 8'd0, 1'b1, 1'b1);
    send_item(OP_TICK, 8'd0, 1'b0, 1'b0);    // active-low set edge
  endtask

  task automatic test_random_setups();
    apply_setup(16'd5, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1);
    random_phase(110);
    apply_setup(16'd0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0);
    random_phase(100);
    apply_setup(16'hFFFF, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1);
    random_phase(100);
    // Long run with no idling on either side.
    calm = 1'b1;
    apply_setup(16'd12, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0);
    random_phase(120);
    calm = 1'b0;
    apply_setup(16'd3, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
    random_phase(100);
    apply_setup(16'd1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1);
    random_phase(100);
    repeat (2) begin
      apply_setup(16'($urandom_range(40)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      random_phase(90);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_commands();
    test_timeout();
    test_feedback_polarity();
    test_random_setups();
    settle();
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/lrdc_pkg.sv
src/latching_relay_drive_controller.sv
verif/testbench.sv
